[sv/sha1_pkg.sv]
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [6:0]  round_t;

	localparam round_t LAST_ROUND = 7'd79;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam word_t K_ROUND_0 = 32'h5A827999;
	localparam word_t K_ROUND_1 = 32'h6ED9EBA1;
	localparam word_t K_ROUND_2 = 32'h8F1BBCDC;
	localparam word_t K_ROUND_3 = 32'hCA62C1D6;

	localparam word_t H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	// schedule window control
	typedef struct packed {
		logic       load;   // shift one byte in
		logic       step;   // advance one schedule word
		logic [7:0] data;
	} sched_ctl_t;

	// round unit control
	typedef struct packed {
		logic   load;       // take chaining words as a..e
		logic   step;       // run one round
		round_t round;
	} round_ctl_t;

	function automatic word_t round_k(round_t r);
		word_t k;
		if (r < 7'd20) begin
			k = K_ROUND_0;
		end else if (r < 7'd40) begin
			k = K_ROUND_1;
		end else if (r < 7'd60) begin
			k = K_ROUND_2;
		end else begin
			k = K_ROUND_3;
		end
		return k;
	endfunction

	function automatic word_t round_f(round_t r, word_t b, word_t c, word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r >= 7'd40 && r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

[sv/sha1_message_digest.sv]
// Channel | dir | tdata               | tuser           | tlast
// s_      | in  | data_byte[7:0]      | byte_present    | end_of_message
// m_      | out | digest_word[31:0]   | word_index[2:0] | last_word
//
// Bytes are taken one per cycle while idle; a 64th byte starts compression
// through the one round unit, followed by the chaining add. Padding bytes
// are fed one per cycle outside compression (up to 72, plus a second
// compression), then five words go out. s_tready is low from block-full
// until the compression ends and during padding and digest output;
// m_tready stalls simply hold the current word.
// arst_n restores the initial chaining words and clears the bit count.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [0:0]  s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   pad_q;
	logic [5:0]  pos_q;
	logic [63:0] bit_count_q;
	logic [63:0] total_q;
	sha1_pkg::round_t round_q;
	sha1_pkg::word_t  h_q [sha1_pkg::DIGEST_WORDS];
	logic [2:0] out_idx_q;
	logic       m_tvalid_q;

	logic s_accept, m_accept;
	logic pad_len, absorb, block_full;
	logic [7:0] pad_byte;
	sha1_pkg::sched_ctl_t sched_ctl;
	sha1_pkg::round_ctl_t round_ctl;
	sha1_pkg::word_t w_cur;
	sha1_pkg::word_t a_w, b_w, c_w, d_w, e_w;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_accept = m_tvalid_q && m_tready;

	// length bytes start once the zero fill has reached offset 56
	assign pad_len  = (phase_q == PH_LEN) || (phase_q == PH_ZERO && pos_q == 6'd56);
	assign pad_byte = (phase_q == PH_MARK) ? sha1_pkg::PAD_MARK :
		(pad_len ? total_q[63:56] : 8'h00);

	assign absorb     = (s_accept && s_tuser[0]) || (state_q == ST_PAD);
	assign block_full = absorb && (pos_q == 6'd63);

	assign sched_ctl.load = absorb;
	assign sched_ctl.step = (state_q == ST_ROUND);
	assign sched_ctl.data = (state_q == ST_PAD) ? pad_byte : s_tdata;

	assign round_ctl.load  = block_full;
	assign round_ctl.step  = (state_q == ST_ROUND);
	assign round_ctl.round = round_q;

	sha1_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.clk   (clk),
		.ctl   (round_ctl),
		.h_in  (h_q),
		.w_cur (w_cur),
		.a_out (a_w),
		.b_out (b_w),
		.c_out (c_w),
		.d_out (d_w),
		.e_out (e_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MARK;
			pad_q       <= 1'b0;
			pos_q       <= '0;
			bit_count_q <= '0;
			total_q     <= '0;
			round_q     <= '0;
			h_q         <= sha1_pkg::H_INIT;
			out_idx_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (absorb) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (s_tuser[0]) begin
							bit_count_q <= bit_count_q + 64'd8;
						end
						if (s_tlast) begin
							pad_q   <= 1'b1;
							phase_q <= PH_MARK;
							total_q <= bit_count_q + (s_tuser[0] ? 64'd8 : 64'd0);
						end
						if (block_full) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (phase_q == PH_MARK) begin
						phase_q <= PH_ZERO;
					end else if (pad_len) begin
						phase_q <= PH_LEN;
						total_q <= {total_q[55:0], 8'h00};
					end
					if (block_full) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1_pkg::LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					h_q[0] <= h_q[0] + a_w;
					h_q[1] <= h_q[1] + b_w;
					h_q[2] <= h_q[2] + c_w;
					h_q[3] <= h_q[3] + d_w;
					h_q[4] <= h_q[4] + e_w;
					// the length bytes always close a block, so this was the last one
					if (pad_q && phase_q == PH_LEN) begin
						state_q    <= ST_OUT;
						out_idx_q  <= '0;
						m_tvalid_q <= 1'b1;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_accept) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'(sha1_pkg::DIGEST_WORDS - 1)) begin
							h_q         <= sha1_pkg::H_INIT;
							state_q     <= ST_IDLE;
							m_tvalid_q  <= 1'b0;
							pad_q       <= 1'b0;
							phase_q     <= PH_MARK;
							bit_count_q <= '0;
							pos_q       <= '0;
						end else begin
							for (int i = 0; i < sha1_pkg::DIGEST_WORDS - 1; i++) begin
								h_q[i] <= h_q[i+1];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = h_q[0];
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == 3'(sha1_pkg::DIGEST_WORDS - 1));

`ifndef NO_ASSERTIONS
	a_valid_only_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q == (state_q == ST_OUT))
		else $error("output valid outside digest output");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> round_q <= sha1_pkg::LAST_ROUND)
		else $error("round counter past last round");

	a_pad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD |-> pad_q)
		else $error("padding without end of message");

	a_ready_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after last digest word");

	a_len_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD && phase_q == PH_LEN |-> pos_q >= 6'd57)
		else $error("length bytes off the 56 byte boundary");
`endif

endmodule

[sv/sha1_sched.sv]
// 16-word message window: bytes shift in during load, then one schedule
// word is consumed and one generated per round.
module sha1_sched (
	input  logic                 clk,
	input  sha1_pkg::sched_ctl_t ctl,
	output sha1_pkg::word_t      w_cur
);

	sha1_pkg::word_t win_q [16];
	sha1_pkg::word_t w_next;

	assign w_next = (win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
	assign w_cur  = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctl.data};
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= {w_next[30:0], w_next[31]};
		end
	end

endmodule

[sv/sha1_round.sv]
// Working variables a..e and the single round adder.
module sha1_round (
	input  logic                 clk,
	input  sha1_pkg::round_ctl_t ctl,
	input  sha1_pkg::word_t      h_in [sha1_pkg::DIGEST_WORDS],
	input  sha1_pkg::word_t      w_cur,
	output sha1_pkg::word_t      a_out,
	output sha1_pkg::word_t      b_out,
	output sha1_pkg::word_t      c_out,
	output sha1_pkg::word_t      d_out,
	output sha1_pkg::word_t      e_out
);

	sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1_pkg::word_t t_sum;

	assign t_sum = {a_q[26:0], a_q[31:27]}
		+ sha1_pkg::round_f(ctl.round, b_q, c_q, d_q)
		+ e_q + sha1_pkg::round_k(ctl.round) + w_cur;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_in[0];
			b_q <= h_in[1];
			c_q <= h_in[2];
			d_q <= h_in[3];
			e_q <= h_in[4];
		end else if (ctl.step) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};  // rotate left 30
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign a_out = a_q;
	assign b_out = b_q;
	assign c_out = c_q;
	assign d_out = d_q;
	assign e_out = e_q;

endmodule

[verif/sha1_digest_checker.sv]
// Watches both channels, runs its own SHA-1 on every accepted byte marked
// present and compares each digest word with the oldest one still owed.
module sha1_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [0:0]  s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // digest_word
	input  logic [2:0]  m_tuser,   // word_index
	input  logic        m_tlast,   // last_word
	output int          outstanding,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sha1_pkg::word_t value;
		logic [2:0]      index;
		logic            last;
	} digest_word_t;

	sha1_pkg::word_t chain [sha1_pkg::DIGEST_WORDS];
	logic [7:0]   blk [64];
	logic [63:0]  msg_bits;
	digest_word_t digest_q [$];

	function automatic void restart_hash();
		chain = sha1_pkg::H_INIT;
		msg_bits = '0;
	endfunction

	function automatic void compress_block();
		sha1_pkg::word_t w [80];
		sha1_pkg::word_t a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++) begin
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		end
		for (int r = 16; r < 80; r++) begin
			t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
			w[r] = {t[30:0], t[31]};
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1_pkg::K_ROUND_0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1_pkg::K_ROUND_1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1_pkg::K_ROUND_2;
			end else begin
				f = b ^ c ^ d;
				k = sha1_pkg::K_ROUND_3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void absorb(logic [7:0] v);
		logic [5:0] pos;
		pos = msg_bits[8:3];
		blk[pos] = v;
		msg_bits += 64'd8;
		if (pos == 6'd63) begin
			compress_block();
		end
	endfunction

	// pad, append the length, queue the five digest words
	function automatic void finish_message();
		logic [63:0]  total;
		digest_word_t dw;
		total = msg_bits;
		absorb(sha1_pkg::PAD_MARK);
		while (msg_bits[8:3] != 6'd56) begin
			absorb(8'h00);
		end
		for (int i = 0; i < 8; i++) begin
			absorb(total[63 - 8*i -: 8]);
		end
		for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
			dw.value = chain[i];
			dw.index = 3'(i);
			dw.last  = (i == sha1_pkg::DIGEST_WORDS - 1);
			digest_q.push_back(dw);
		end
		restart_hash();
	endfunction

	initial begin
		restart_hash();
		outstanding = 0;
		mismatches = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		digest_word_t want;
		if (!arst_n) begin
			restart_hash();
			digest_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					mismatches++;
					$display("%0t: digest word %h index %0d with no word expected",
						$time, m_tdata, m_tuser);
				end else begin
					want = digest_q.pop_front();
					if (m_tdata !== want.value) begin
						mismatches++;
						$display("%0t: digest_word expected %h actual %h",
							$time, want.value, m_tdata);
					end
					if (m_tuser !== want.index) begin
						mismatches++;
						$display("%0t: word_index expected %0d actual %0d",
							$time, want.index, m_tuser);
					end
					if (m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: last_word expected %b actual %b",
							$time, want.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					absorb(s_tdata);
				end
				if (s_tlast) begin
					finish_message();
				end
			end
		end
		outstanding = digest_q.size();
	end

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// lengths around the padding and block boundaries
	localparam int EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int outstanding;
	int mismatches;
	int fed_items = 0;
	int messages = 0;
	bit steady = 1'b0;

	sha1_message_digest u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sha1_digest_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 6);
	end

	task automatic feed_word(input logic [7:0] value, input logic present, input logic ends);
		if (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= present;
		s_tlast  <= ends;
		do @(posedge clk); while (!s_tready);
		if (present || ends) begin
			fed_items++;
		end
	endtask

	// the last byte carries the end mark, or a bare end word follows
	task automatic send_message(input int len);
		logic tail_byte;
		tail_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5) begin
				feed_word(8'($urandom), 1'b0, 1'b0);
			end
			feed_word(8'($urandom), 1'b1, tail_byte && (i == len - 1));
		end
		if (!tail_byte) begin
			feed_word(8'($urandom), 1'b0, 1'b1);
		end
		messages++;
	endtask

	initial begin
		#(2_000_000);
		$display("FAIL sha1_message_digest");
		$finish;
	end

	initial begin
		int roll;
		int len;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message; the data byte must be ignored
		feed_word(8'h3C, 1'b0, 1'b1);
		// idle word changes nothing
		feed_word(8'hA5, 1'b0, 1'b0);
		// "abc", end mark on the last byte
		feed_word(8'h61, 1'b1, 1'b0);
		feed_word(8'h62, 1'b1, 1'b0);
		feed_word(8'h63, 1'b1, 1'b1);
		// byte extremes, idle in the middle, bare end word
		feed_word(8'h00, 1'b1, 1'b0);
		feed_word(8'hFF, 1'b1, 1'b0);
		feed_word(8'h5A, 1'b0, 1'b0);
		feed_word(8'hC3, 1'b0, 1'b1);
		// single byte with end mark
		feed_word(8'hFF, 1'b1, 1'b1);
		feed_word(8'h80, 1'b1, 1'b0);
		feed_word(8'h7F, 1'b1, 1'b0);
		feed_word(8'h01, 1'b1, 1'b1);

		// hold off until every digest word is back
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		while (fed_items < 250 || messages < 6) begin
			steady = (messages >= 2) && (messages < 5);
			roll = $urandom_range(9);
			if (roll < 5) begin
				len = $urandom_range(8);
			end else if (roll < 9) begin
				len = EDGE_LENS[$urandom_range(7)];
			end else begin
				len = $urandom_range(130);
			end
			send_message(len);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		if (mismatches == 0) begin
			$display("PASS sha1_message_digest");
		end else begin
			$display("FAIL sha1_message_digest");
		end
		$finish;
	end

endmodule

[sim.f]
sv/sha1_pkg.sv
sv/sha1_sched.sv
sv/sha1_round.sv
sv/sha1_message_digest.sv
verif/sha1_digest_checker.sv
verif/testbench.sv
